// ===== hw/rtl/fbra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbra_pkg - shared types for the four-bit Booth / restoring ALU
// Command codes and the control word that travels down the step chain.
// ----------------------------------------------------------------------------
package fbra_pkg;

	// operation codes, as carried on the command port
	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	// control word handed from cell to cell alongside the data
	typedef struct packed {
		cmd_t cmd;
		logic qprev;   // Booth: multiplier bit shifted out last step
		logic sign_q;  // divide: quotient is negative
		logic sign_r;  // divide: remainder is negative
		logic carry;   // add: carry out of the top bit
	} ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fbra_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbra_prep - operand preparation stage
// Seeds the step chain: add/sub done here, Booth and divide registers loaded,
// divide operands folded to magnitudes with their signs kept aside.
// ----------------------------------------------------------------------------
module fbra_prep
	import fbra_pkg::*;
#(
	parameter int W = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   cmd_in,
	input  wire logic [W-1:0] a_in,
	input  wire logic [W-1:0] b_in,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      acc_out,
	output logic [W-1:0]      q_out,
	output logic [W-1:0]      m_out,
	output ctl_t              ctl_out
);

	logic         valid_q;
	logic [W-1:0] acc_q, q_q, m_q;
	ctl_t         ctl_q;

	logic [W:0]   sum;
	logic [W-1:0] mag_a, mag_b;
	logic [W-1:0] acc_d, q_d, m_d;
	ctl_t         ctl_d;

	assign in_ready = !valid_q || out_ready;

	// seed values per command
	always_comb begin
		sum   = {1'b0, a_in} + {1'b0, b_in};
		mag_a = a_in[W-1] ? ({W{1'b0}} - a_in) : a_in;
		mag_b = b_in[W-1] ? ({W{1'b0}} - b_in) : b_in;
		acc_d = {W{1'b0}};
		q_d   = {W{1'b0}};
		m_d   = {W{1'b0}};
		ctl_d = '0;
		ctl_d.cmd = cmd_t'(cmd_in);
		case (cmd_t'(cmd_in))
			CMD_ADD: begin
				acc_d       = sum[W-1:0];
				ctl_d.carry = sum[W];
			end
			CMD_SUB: begin
				acc_d = a_in - b_in;
			end
			CMD_MUL: begin
				q_d = b_in;
				m_d = a_in;
			end
			CMD_DIV: begin
				q_d          = mag_a;
				m_d          = mag_b;
				ctl_d.sign_q = a_in[W-1] ^ b_in[W-1];
				ctl_d.sign_r = a_in[W-1];
			end
			default: begin
				acc_d = {W{1'b0}};
			end
		endcase
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			acc_q <= acc_d;
			q_q   <= q_d;
			m_q   <= m_d;
			ctl_q <= ctl_d;
		end
	end

	assign out_valid = valid_q;
	assign acc_out   = acc_q;
	assign q_out     = q_q;
	assign m_out     = m_q;
	assign ctl_out   = ctl_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fbra_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbra_cell - one step of the multiply / divide chain
// Performs a single radix-2 Booth step or a single restoring divide step,
// and passes add/sub results through untouched.
// ----------------------------------------------------------------------------
module fbra_cell
	import fbra_pkg::*;
#(
	parameter int W = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] acc_in,
	input  wire logic [W-1:0] q_in,
	input  wire logic [W-1:0] m_in,
	input  wire ctl_t         ctl_in,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      acc_out,
	output logic [W-1:0]      q_out,
	output logic [W-1:0]      m_out,
	output ctl_t              ctl_out
);

	logic         valid_q;
	logic [W-1:0] acc_q, q_q, m_q;
	ctl_t         ctl_q;

	logic [W-1:0] booth_acc, shl_acc, trial;
	logic [W-1:0] acc_d, q_d;
	ctl_t         ctl_d;

	assign in_ready = !valid_q || out_ready;

	// step logic
	always_comb begin
		booth_acc = acc_in;
		shl_acc   = {acc_in[W-2:0], q_in[W-1]};
		trial     = shl_acc - m_in;
		acc_d     = acc_in;
		q_d       = q_in;
		ctl_d     = ctl_in;
		case (ctl_in.cmd)
			CMD_MUL: begin
				// 10 subtracts, 01 adds, then arithmetic shift of {acc, q}
				if (q_in[0] && !ctl_in.qprev) begin
					booth_acc = acc_in - m_in;
				end else if (!q_in[0] && ctl_in.qprev) begin
					booth_acc = acc_in + m_in;
				end
				ctl_d.qprev = q_in[0];
				q_d         = {booth_acc[0], q_in[W-1:1]};
				acc_d       = {booth_acc[W-1], booth_acc[W-1:1]};
			end
			CMD_DIV: begin
				// shift, trial subtract, restore when negative
				if (trial[W-1]) begin
					acc_d = shl_acc;
					q_d   = {q_in[W-2:0], 1'b0};
				end else begin
					acc_d = trial;
					q_d   = {q_in[W-2:0], 1'b1};
				end
			end
			default: begin
				acc_d = acc_in;
			end
		endcase
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			acc_q <= acc_d;
			q_q   <= q_d;
			m_q   <= m_in;
			ctl_q <= ctl_d;
		end
	end

	assign out_valid = valid_q;
	assign acc_out   = acc_q;
	assign q_out     = q_q;
	assign m_out     = m_q;
	assign ctl_out   = ctl_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fbra_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbra_out - result formatting and output register
// Applies the divide sign fix-ups, packs the product and holds the result
// until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module fbra_out
	import fbra_pkg::*;
#(
	parameter int W = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] acc_in,
	input  wire logic [W-1:0] q_in,
	input  wire ctl_t         ctl_in,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [2*W-1:0]    result_value,
	output logic [W-1:0]      remainder,
	output logic              carry_out
);

	logic           valid_q;
	logic [2*W-1:0] res_q;
	logic [W-1:0]   rem_q;
	logic           carry_q;

	logic [2*W-1:0] res_d;
	logic [W-1:0]   rem_d, quot;
	logic           carry_d;

	assign in_ready = !valid_q || out_ready;

	// format per command
	always_comb begin
		quot    = ctl_in.sign_q ? ({W{1'b0}} - q_in) : q_in;
		res_d   = {{W{1'b0}}, acc_in};
		rem_d   = {W{1'b0}};
		carry_d = 1'b0;
		case (ctl_in.cmd)
			CMD_ADD: begin
				carry_d = ctl_in.carry;
			end
			CMD_SUB: begin
				res_d = {{W{1'b0}}, acc_in};
			end
			CMD_MUL: begin
				res_d = {acc_in, q_in};
			end
			CMD_DIV: begin
				res_d = {{W{1'b0}}, quot};
				rem_d = ctl_in.sign_r ? ({W{1'b0}} - acc_in) : acc_in;
			end
			default: begin
				res_d = {{W{1'b0}}, acc_in};
			end
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q   <= res_d;
			rem_q   <= rem_d;
			carry_q <= carry_d;
		end
	end

	assign out_valid    = valid_q;
	assign result_value = res_q;
	assign remainder    = rem_q;
	assign carry_out    = carry_q;

endmodule
`default_nettype wire

// ===== hw/rtl/four_bit_booth_restoring_alu_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// four_bit_booth_restoring_alu_core - pipelined add/sub/Booth/divide ALU
// One command and two operands in, one result out per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : in_valid/in_ready with command, operand_a, operand_b.
//   Output channel : out_valid/out_ready with result_value, remainder,
//                    carry_out.
//   The operands pass a preparation stage, a chain of DATA_WIDTH step cells
//   (one Booth or restoring step each) and a formatting/output register.
//   out_valid rises once the operation has been registered in turn in the
//   preparation stage, in every step cell and in the output register; one
//   item is accepted every cycle while no stall backs the chain up, the
//   rate being set by the cell chain, which advances one step per cycle.
//   Every stage has its own valid bit, so a stalled receiver only holds the
//   output register; empty stages behind it keep filling, and in_ready drops
//   once the whole chain is full. Results leave in input order.
//   Reset clears all valid bits; in_ready is held low until the first clock
//   after arst_n is released.
// ----------------------------------------------------------------------------
module four_bit_booth_restoring_alu_core
	import fbra_pkg::*;
#(
	parameter int DATA_WIDTH = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              command,
	input  wire logic signed [DATA_WIDTH-1:0] operand_a,
	input  wire logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [2*DATA_WIDTH-1:0]      result_value,
	output logic [DATA_WIDTH-1:0]        remainder,
	output logic                         carry_out
);

	localparam int W = DATA_WIDTH;

	logic         rst_done_q;
	logic         prep_ready;

	// chain links: index 0 is the prep stage output, index W the last cell
	logic         lnk_valid [0:W];
	logic         lnk_ready [0:W];
	logic [W-1:0] lnk_acc   [0:W];
	logic [W-1:0] lnk_q     [0:W];
	logic [W-1:0] lnk_m     [0:W];
	ctl_t         lnk_ctl   [0:W];

	// hold off input transfers until out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_done_q <= 1'b0;
		end else begin
			rst_done_q <= 1'b1;
		end
	end

	assign in_ready = prep_ready && rst_done_q;

	// operand preparation
	fbra_prep #(.W(W)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid && rst_done_q),
		.in_ready  (prep_ready),
		.cmd_in    (command),
		.a_in      ($unsigned(operand_a)),
		.b_in      ($unsigned(operand_b)),
		.out_valid (lnk_valid[0]),
		.out_ready (lnk_ready[0]),
		.acc_out   (lnk_acc[0]),
		.q_out     (lnk_q[0]),
		.m_out     (lnk_m[0]),
		.ctl_out   (lnk_ctl[0])
	);

	// step cells
	for (genvar i = 0; i < W; i++) begin : g_cell
		fbra_cell #(.W(W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lnk_valid[i]),
			.in_ready  (lnk_ready[i]),
			.acc_in    (lnk_acc[i]),
			.q_in      (lnk_q[i]),
			.m_in      (lnk_m[i]),
			.ctl_in    (lnk_ctl[i]),
			.out_valid (lnk_valid[i+1]),
			.out_ready (lnk_ready[i+1]),
			.acc_out   (lnk_acc[i+1]),
			.q_out     (lnk_q[i+1]),
			.m_out     (lnk_m[i+1]),
			.ctl_out   (lnk_ctl[i+1])
		);
	end

	// result formatting and output register
	fbra_out #(.W(W)) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (lnk_valid[W]),
		.in_ready     (lnk_ready[W]),
		.acc_in       (lnk_acc[W]),
		.q_in         (lnk_q[W]),
		.ctl_in       (lnk_ctl[W]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.remainder    (remainder),
		.carry_out    (carry_out)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/fbra_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbra_checker - port-level assertions for the ALU core
// Output channel stability plus back-pressure and result-field consistency.
// ----------------------------------------------------------------------------
module fbra_checker #(
	parameter int DATA_WIDTH = 4
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [2*DATA_WIDTH-1:0]      result_value,
	input wire logic [DATA_WIDTH-1:0]        remainder,
	input wire logic                         carry_out
);

	// a held result keeps valid high
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transfer");

	// a held result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_value) && $stable(remainder)
			&& $stable(carry_out))
		else $error("result changed while stalled");

	// the chain only pushes back when the output register is holding a result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && !in_ready |-> out_valid && !out_ready)
		else $error("in_ready low with output free");

	// a carry comes only from add, which has no remainder and no upper half
	a_carry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carry_out |-> remainder == '0
			&& result_value[2*DATA_WIDTH-1:DATA_WIDTH] == '0)
		else $error("carry set on a non-add result");

endmodule

bind four_bit_booth_restoring_alu_core fbra_checker #(.DATA_WIDTH(DATA_WIDTH)) u_fbra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_value (result_value),
	.remainder    (remainder),
	.carry_out    (carry_out)
);
`default_nettype wire

// ===== tb/tb_four_bit_booth_restoring_alu_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_bit_booth_restoring_alu_core - self-checking bench for the ALU core
// Drives add, subtract, Booth multiply and restoring divide operations through
// the valid/ready input channel and checks every output transfer, field by
// field, against an in-bench model of the arithmetic. Directed edge cases come
// first, then random operands with random gaps on both sides, a full-rate
// stretch and a long receiver hold that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_four_bit_booth_restoring_alu_core;
	import fbra_pkg::*;

	localparam int DW          = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;

	// expected result of one operation
	typedef struct packed {
		logic [2*DW-1:0] value;
		logic [DW-1:0]   rem;
		logic            carry;
	} alu_outcome_t;

	// one accepted operation and what it should produce
	typedef struct {
		cmd_t         op;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		alu_outcome_t  want;
	} alu_job_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           command;
	logic signed [DW-1:0] operand_a;
	logic signed [DW-1:0] operand_b;
	logic                 out_valid;
	logic                 out_ready;
	logic [2*DW-1:0]      result_value;
	logic [DW-1:0]        remainder;
	logic                 carry_out;

	alu_job_t pending_results[$];
	int       mismatches     = 0;
	int       results_checked = 0;
	int       ops_seen[4]    = '{0, 0, 0, 0};
	int       zero_divisors  = 0;
	int       quiet_cycles   = 0;
	bit       tx_idle_en     = 1'b0;
	bit       rx_idle_en     = 1'b0;
	bit       hold_request   = 1'b0;

	four_bit_booth_restoring_alu_core #(
		.DATA_WIDTH(DW)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value),
		.remainder   (remainder),
		.carry_out   (carry_out)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Arithmetic model
	// ------------------------------------------------------------------------

	// radix-2 Booth, accumulator wraps at DW bits, returns {acc, multiplier}
	function automatic logic [2*DW-1:0] booth_product(logic [DW-1:0] mcand,
		logic [DW-1:0] mplier);
		logic [DW-1:0] acc;
		logic [DW-1:0] mq;
		logic          qprev;
		acc   = '0;
		mq    = mplier;
		qprev = 1'b0;
		for (int step = 0; step < DW; step++) begin
			if (!mq[0] && qprev)
				acc = acc + mcand;
			else if (mq[0] && !qprev)
				acc = acc - mcand;
			qprev = mq[0];
			mq    = {acc[0], mq[DW-1:1]};
			acc   = {acc[DW-1], acc[DW-1:1]};
		end
		return {acc, mq};
	endfunction

	// restoring division on magnitudes; sign fix-up afterwards
	function automatic logic [2*DW-1:0] restoring_quot_rem(logic [DW-1:0] dividend,
		logic [DW-1:0] divisor);
		logic [DW-1:0] part;
		logic [DW-1:0] quot;
		logic [DW-1:0] mag;
		logic          neg_q;
		logic          neg_r;
		quot  = dividend;
		mag   = divisor;
		neg_q = dividend[DW-1] ^ divisor[DW-1];
		neg_r = dividend[DW-1];
		part  = '0;
		// most negative value negates to itself and is used as it stands
		if (quot[DW-1])
			quot = -quot;
		if (mag[DW-1])
			mag = -mag;
		for (int step = 0; step < DW; step++) begin
			part = {part[DW-2:0], quot[DW-1]};
			quot = {quot[DW-2:0], 1'b0};
			part = part - mag;
			if (part[DW-1])
				part = part + mag;
			else
				quot[0] = 1'b1;
		end
		if (neg_q)
			quot = -quot;
		if (neg_r)
			part = -part;
		return {quot, part};
	endfunction

	function automatic alu_outcome_t alu_predict(cmd_t op, logic [DW-1:0] a,
		logic [DW-1:0] b);
		alu_outcome_t  res;
		logic [DW:0]   sum;
		logic [2*DW-1:0] qr;
		res = '0;
		case (op)
			CMD_ADD: begin
				sum       = {1'b0, a} + {1'b0, b};
				res.value = {{DW{1'b0}}, sum[DW-1:0]};
				res.carry = sum[DW];
			end
			CMD_SUB: begin
				res.value = {{DW{1'b0}}, a - b};
			end
			CMD_MUL: begin
				res.value = booth_product(a, b);
			end
			default: begin
				qr        = restoring_quot_rem(a, b);
				res.value = {{DW{1'b0}}, qr[2*DW-1:DW]};
				res.rem   = qr[DW-1:0];
			end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Transfer monitor and result checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		alu_job_t     job;
		alu_outcome_t got;
		// input transfer: record what it should produce
		if (in_valid && in_ready) begin
			job.op   = cmd_t'(command);
			job.a    = operand_a;
			job.b    = operand_b;
			job.want = alu_predict(job.op, job.a, job.b);
			pending_results.push_back(job);
			ops_seen[command]++;
			if (job.op == CMD_DIV && job.b == '0)
				zero_divisors++;
		end
		// output transfer: compare with the oldest outstanding operation
		if (out_valid && out_ready) begin
			got = {result_value, remainder, carry_out};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result value=%h rem=%h carry=%b",
						$realtime, got.value, got.rem, got.carry);
			end else begin
				job = pending_results.pop_front();
				results_checked++;
				if (got.value !== job.want.value || got.rem !== job.want.rem ||
						got.carry !== job.want.carry) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: %s a=%h b=%h: value exp %h got %h, ",
							"rem exp %h got %h, carry exp %b got %b"},
							$realtime, job.op.name(), job.a, job.b,
							job.want.value, got.value, job.want.rem, got.rem,
							job.want.carry, got.carry);
				end
			end
		end
	end

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
					quiet_cycles, pending_results.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold on request
	// ------------------------------------------------------------------------
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return $urandom_range(1, 3);
		else if (pick < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (rx_idle_en && $urandom_range(0, 99) < 20)
					stall_left = gap_length();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// offer one operation and wait for its transfer; valid is left high so a
	// following operation can go out on the next cycle
	task automatic send_op(input cmd_t op, input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		int gap;
		gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? gap_length() : 0;
		if (gap > 0) begin
			in_valid  <= 1'b0;
			command   <= 2'($urandom_range(0, 3));
			operand_a <= DW'($urandom_range(0, 15));
			operand_b <= DW'($urandom_range(0, 15));
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random_op();
		cmd_t                 op;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		op = cmd_t'($urandom_range(0, 3));
		a  = DW'($urandom_range(0, 15));
		b  = DW'($urandom_range(0, 15));
		send_op(op, a, b);
	endtask

	// sender pauses until every outstanding result has come back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_add_sub_edges();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_op(CMD_ADD, 7, 7);
		send_op(CMD_ADD, -8, -8);   // carry out, wraps to zero
		send_op(CMD_ADD, -1, 1);
		send_op(CMD_SUB, -8, 7);
		send_op(CMD_SUB, 7, -8);
		send_op(CMD_SUB, 0, -8);
		wait_all_results();
	endtask

	task automatic test_booth_edges();
		send_op(CMD_MUL, 7, 7);
		send_op(CMD_MUL, -8, 7);    // most negative multiplicand, accumulator wraps
		send_op(CMD_MUL, -8, -8);
		send_op(CMD_MUL, 7, -8);
		send_op(CMD_MUL, -1, -1);
		send_op(CMD_MUL, 0, -8);
		send_op(CMD_MUL, 3, -5);
		wait_all_results();
	endtask

	task automatic test_divide_edges();
		send_op(CMD_DIV, 7, 2);
		send_op(CMD_DIV, -7, 2);
		send_op(CMD_DIV, 7, -3);
		send_op(CMD_DIV, -8, 3);    // most negative dividend
		send_op(CMD_DIV, 5, -8);    // most negative divisor
		send_op(CMD_DIV, -8, -8);
		// zero divisor runs the normal step sequence
		send_op(CMD_DIV, 6, 0);
		send_op(CMD_DIV, -5, 0);
		send_op(CMD_DIV, 0, 0);
		send_op(CMD_DIV, -8, 0);
		wait_all_results();
	endtask

	task automatic test_random_traffic(input int count);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (count) send_random_op();
		wait_all_results();
	endtask

	task automatic test_full_rate(input int count);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (count) send_random_op();
		wait_all_results();
	endtask

	// receiver holds off while the sender keeps offering, filling the chain
	task automatic test_output_backpressure(input int count);
		tx_idle_en   = 1'b0;
		rx_idle_en   = 1'b0;
		hold_request = 1'b1;
		repeat (count) send_random_op();
		wait_all_results();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CMD_ADD;
		operand_a <= '0;
		operand_b <= '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_sub_edges();
		test_booth_edges();
		test_divide_edges();
		test_random_traffic(800);
		test_output_backpressure(48);
		test_full_rate(250);
		test_random_traffic(700);

		// let any stray result show up
		wait_all_results();
		repeat (DW + 8) @(posedge clk);

		$display("Checked %0d results: %0d add, %0d sub, %0d mul, %0d div (%0d zero divisor)",
			results_checked, ops_seen[CMD_ADD], ops_seen[CMD_SUB], ops_seen[CMD_MUL],
			ops_seen[CMD_DIV], zero_divisors);
		$display("Traffic: edge cases, random gaps both sides, full rate, %0d-cycle output hold",
			HOLD_CYCLES);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== four_bit_booth_restoring_alu_core.f =====
hw/rtl/fbra_pkg.sv
hw/rtl/fbra_prep.sv
hw/rtl/fbra_cell.sv
hw/rtl/fbra_out.sv
hw/rtl/four_bit_booth_restoring_alu_core.sv
hw/rtl/fbra_checker.sv
tb/tb_four_bit_booth_restoring_alu_core.sv
